[rtl/modular_exponentiation_assert.svh]
// ----------------------------------------------------------------------------
// modular_exponentiation_assert.svh
// Assertion macros used by the modular exponentiation checker.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Checked on every rising edge of clk outside reset.
`define MEXP_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define MEXP_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Types and constants shared by the modular exponentiation modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  // Width of the base, the result and both configuration registers.
  localparam int unsigned FIELD_W   = 63;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FIELD_W-1:0] EXPONENT_RESET = 63'd900000000000000000;
  // Product of the two primes 3000000007 and 3000000011.
  localparam logic [FIELD_W-1:0] MODULUS_RESET  = 63'd9000000054000000077;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPONENT = 2'd0,
    CFG_MODULUS  = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_SET_SPECIAL,
    DP_LOAD_RED,
    DP_STEP_DBL,
    DP_STEP_ADD,
    DP_RED_END,
    DP_LOAD_MUL,
    DP_MUL_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic mod_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/mexp_in_if.sv]
// ----------------------------------------------------------------------------
// mexp_in_if
// Request channel carrying one base value.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_in_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::FIELD_W-1:0] base_value;

  modport source (output valid, output base_value, input ready);
  modport sink   (input valid, input base_value, output ready);
endinterface

`default_nettype wire

[rtl/mexp_out_if.sv]
// ----------------------------------------------------------------------------
// mexp_out_if
// Result channel carrying one power residue.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_out_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::FIELD_W-1:0] power_residue;

  modport source (output valid, output power_residue, input ready);
  modport sink   (input valid, input power_residue, output ready);
endinterface

`default_nettype wire

[rtl/mexp_cfg_if.sv]
// ----------------------------------------------------------------------------
// mexp_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mexp_pkg::CFG_IDX_W-1:0] index;
  logic [mexp_pkg::FIELD_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/mexp_mulmod.sv]
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: one doubling or one conditional add per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod #(
  parameter int unsigned W = 63
) (
  input  wire logic         clk,
  input  wire logic         load,
  input  wire logic         step_dbl,
  input  wire logic         step_add,
  input  wire logic [W-1:0] a_in,
  input  wire logic [W-1:0] b_in,
  input  wire logic [W-1:0] m_in,
  output logic      [W-1:0] acc
);

  logic [W-1:0] acc_r;
  logic [W-1:0] a_r;
  logic [W-1:0] b_r;
  logic [W:0]   sum;
  logic [W:0]   red;
  logic [W-1:0] acc_nxt;

  // The accumulator stays below m, so one conditional subtract restores it
  // after either a doubling or an add of a value no larger than m.
  always_comb begin
    if (step_dbl) begin
      sum = {acc_r, 1'b0};
    end else begin
      sum = {1'b0, acc_r} + (b_r[W-1] ? {1'b0, a_r} : '0);
    end
    red     = (sum >= {1'b0, m_in}) ? (sum - {1'b0, m_in}) : sum;
    acc_nxt = red[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r <= '0;
      a_r   <= a_in;
      b_r   <= b_in;
    end else if (step_dbl) begin
      acc_r <= acc_nxt;
    end else if (step_add) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[W-2:0], 1'b0};
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

[rtl/mexp_datapath.sv]
// ----------------------------------------------------------------------------
// mexp_datapath
// Configuration registers, operand registers and two serial multipliers.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_datapath #(
  parameter int unsigned P = 63
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire mexp_pkg::dp_cmd_t                cmd,
  output mexp_pkg::dp_stat_t                    stat,
  input  wire logic                             cfg_we,
  input  wire logic [mexp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mexp_pkg::FIELD_W-1:0]     cfg_data,
  input  wire logic [mexp_pkg::FIELD_W-1:0]     in_base,
  output logic      [mexp_pkg::FIELD_W-1:0]     out_data
);

  logic [P-1:0] exponent_r;
  logic [P-1:0] modulus_r;
  logic [P-1:0] base_r,   base_nxt;
  logic [P-1:0] exp_sh_r, exp_sh_nxt;
  logic [P-1:0] power_r,  power_nxt;
  logic [P-1:0] result_r, result_nxt;
  logic [mexp_pkg::FIELD_W-1:0] out_data_r;

  logic         mod_one;
  logic         unit_load;
  logic         unit_dbl;
  logic         unit_add;
  logic [P-1:0] a_op_a;
  logic [P-1:0] a_op_b;
  logic [P-1:0] acc_a;
  logic [P-1:0] acc_b;

  assign stat.exp_zero = (exponent_r == '0);
  assign stat.mod_zero = (modulus_r == '0);
  assign mod_one       = (modulus_r == P'(1));

  assign unit_load = (cmd.op == mexp_pkg::DP_LOAD_RED) || (cmd.op == mexp_pkg::DP_LOAD_MUL);
  assign unit_dbl  = (cmd.op == mexp_pkg::DP_STEP_DBL);
  assign unit_add  = (cmd.op == mexp_pkg::DP_STEP_ADD);

  // Reduction of the base runs as 1 * base mod m on unit A.
  assign a_op_a = (cmd.op == mexp_pkg::DP_LOAD_RED) ? P'(1)  : result_r;
  assign a_op_b = (cmd.op == mexp_pkg::DP_LOAD_RED) ? base_r : power_r;

  mexp_mulmod #(.W(P)) u_mul_res (
    .clk      (clk),
    .load     (unit_load),
    .step_dbl (unit_dbl),
    .step_add (unit_add),
    .a_in     (a_op_a),
    .b_in     (a_op_b),
    .m_in     (modulus_r),
    .acc      (acc_a)
  );

  mexp_mulmod #(.W(P)) u_mul_sq (
    .clk      (clk),
    .load     (unit_load),
    .step_dbl (unit_dbl),
    .step_add (unit_add),
    .a_in     (power_r),
    .b_in     (power_r),
    .m_in     (modulus_r),
    .acc      (acc_b)
  );

  always_comb begin
    base_nxt   = base_r;
    exp_sh_nxt = exp_sh_r;
    power_nxt  = power_r;
    result_nxt = result_r;
    case (cmd.op)
      mexp_pkg::DP_CAPTURE: begin
        base_nxt   = in_base[P-1:0];
        exp_sh_nxt = exponent_r;
      end
      mexp_pkg::DP_SET_SPECIAL: begin
        result_nxt = stat.exp_zero ? P'(1) : '0;
      end
      mexp_pkg::DP_RED_END: begin
        power_nxt  = acc_a;
        result_nxt = mod_one ? '0 : P'(1);
      end
      mexp_pkg::DP_MUL_END: begin
        if (exp_sh_r[0]) begin
          result_nxt = acc_a;
        end
        power_nxt  = acc_b;
        exp_sh_nxt = exp_sh_r >> 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= mexp_pkg::EXPONENT_RESET[P-1:0];
      modulus_r  <= mexp_pkg::MODULUS_RESET[P-1:0];
    end else if (cfg_we) begin
      if (cfg_index == mexp_pkg::CFG_EXPONENT) begin
        exponent_r <= cfg_data[P-1:0];
      end else if (cfg_index == mexp_pkg::CFG_MODULUS) begin
        modulus_r <= cfg_data[P-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    exp_sh_r <= exp_sh_nxt;
    power_r  <= power_nxt;
    result_r <= result_nxt;
    if (cmd.out_load) begin
      out_data_r <= mexp_pkg::FIELD_W'(result_r);
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

[rtl/mexp_ctrl.sv]
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for base reduction and the square-and-multiply loop.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl #(
  parameter int unsigned P = 63
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire mexp_pkg::dp_stat_t stat,
  output mexp_pkg::dp_cmd_t       cmd
);

  localparam int unsigned CNT_W = $clog2(P);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_RED_DBL,
    ST_RED_ADD,
    ST_RED_END,
    ST_MUL_LOAD,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_MUL_END,
    ST_FINISH
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] bit_cnt_r;
  logic [CNT_W-1:0] exp_cnt_r;
  logic             out_valid_r;
  logic             in_acc;
  logic             out_free;
  logic             special;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign special  = stat.exp_zero || stat.mod_zero;

  always_comb begin
    cmd.op       = mexp_pkg::DP_NOP;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE:     cmd.op = in_acc ? mexp_pkg::DP_CAPTURE : mexp_pkg::DP_NOP;
      ST_PREP:     cmd.op = special ? mexp_pkg::DP_SET_SPECIAL : mexp_pkg::DP_LOAD_RED;
      ST_RED_DBL:  cmd.op = mexp_pkg::DP_STEP_DBL;
      ST_RED_ADD:  cmd.op = mexp_pkg::DP_STEP_ADD;
      ST_RED_END:  cmd.op = mexp_pkg::DP_RED_END;
      ST_MUL_LOAD: cmd.op = mexp_pkg::DP_LOAD_MUL;
      ST_MUL_DBL:  cmd.op = mexp_pkg::DP_STEP_DBL;
      ST_MUL_ADD:  cmd.op = mexp_pkg::DP_STEP_ADD;
      ST_MUL_END:  cmd.op = mexp_pkg::DP_MUL_END;
      ST_FINISH:   cmd.out_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_cnt_r   <= '0;
      exp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In ST_FINISH the valid flag is set below instead.
      if (out_valid_r && out_ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          bit_cnt_r <= CNT_W'(P - 1);
          state_r   <= special ? ST_FINISH : ST_RED_DBL;
        end
        ST_RED_DBL: begin
          state_r <= ST_RED_ADD;
        end
        ST_RED_ADD: begin
          if (bit_cnt_r == '0) begin
            state_r <= ST_RED_END;
          end else begin
            bit_cnt_r <= bit_cnt_r - 1'b1;
            state_r   <= ST_RED_DBL;
          end
        end
        ST_RED_END: begin
          exp_cnt_r <= CNT_W'(P - 1);
          state_r   <= ST_MUL_LOAD;
        end
        ST_MUL_LOAD: begin
          bit_cnt_r <= CNT_W'(P - 1);
          state_r   <= ST_MUL_DBL;
        end
        ST_MUL_DBL: begin
          state_r <= ST_MUL_ADD;
        end
        ST_MUL_ADD: begin
          if (bit_cnt_r == '0) begin
            state_r <= ST_MUL_END;
          end else begin
            bit_cnt_r <= bit_cnt_r - 1'b1;
            state_r   <= ST_MUL_DBL;
          end
        end
        ST_MUL_END: begin
          if (exp_cnt_r == '0) begin
            state_r <= ST_FINISH;
          end else begin
            exp_cnt_r <= exp_cnt_r - 1'b1;
            state_r   <= ST_MUL_LOAD;
          end
        end
        ST_FINISH: begin
          // The result moves into the output register once it is free.
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises each base to the configured exponent modulo the configured modulus.
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   base_value[62:0]
//   out_chan  out  valid/ready   power_residue[62:0]
//   cfg_chan  in   valid/ready   index[1:0], data[62:0] (0 exponent, 1 modulus)
//
// A request runs from acceptance to result through a base reduction, then
// P passes through the two bit-serial modular multipliers, which run the
// multiply and the square side by side. Exponent zero or modulus zero skip
// both and go straight from preparation to the result. One request is in
// work at a time; a new one is taken while the previous result waits in the
// output register. Reset is synchronous; cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
  parameter int unsigned OPERAND_BITS = 63
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  mexp_in_if.sink       in_chan,
  mexp_out_if.source    out_chan,
  mexp_cfg_if.sink      cfg_chan
);

  mexp_pkg::dp_cmd_t  cmd;
  mexp_pkg::dp_stat_t stat;
  logic               in_ready;
  logic               out_valid;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  mexp_ctrl #(.P(OPERAND_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mexp_datapath #(.P(OPERAND_BITS)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_chan.valid),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .in_base   (in_chan.base_value),
    .out_data  (out_chan.power_residue)
  );

endmodule

`default_nettype wire

[rtl/mexp_checker.sv]
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on request and result ordering, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_assert.svh"

module mexp_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [mexp_pkg::FIELD_W-1:0] out_data
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests accepted whose results have not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pend_r <= (pend_r == 2'd3) ? pend_r : pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= (pend_r == 2'd0) ? pend_r : pend_r - 2'd1;
    end
  end

  `MEXP_ASSERT_ANY(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `MEXP_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result dropped or changed")
  `MEXP_ASSERT_RUN(a_no_phantom, out_valid |-> pend_r != 2'd0, "result without a request")
  `MEXP_ASSERT_RUN(a_one_in_work, in_acc |-> pend_r < 2'd2, "request taken while another is in work")
  `MEXP_ASSERT_RUN(a_busy_after_take, in_acc |=> !in_ready, "ready while a request is in work")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.power_residue)
);

`default_nettype wire
